[hw/rtl/mkd_pkg.sv]
package mkd_pkg;

  // Width of one row's column levels and of a key code.
  localparam int unsigned COLS   = 4;
  localparam int unsigned ROWS   = 4;
  localparam int unsigned CODE_W = 5;
  localparam int unsigned CNT_W  = 4;

  typedef logic [COLS-1:0]   levels_t;
  typedef logic [CODE_W-1:0] code_t;
  typedef logic [CNT_W-1:0]  count_t;

  // Code meaning that no key is pressed.
  localparam code_t KEY_NONE = '0;

  // Stable scan threshold after reset.
  localparam count_t STABLE_SCANS_RST = 4'd3;

  // Scan word as held in the input register.
  typedef struct packed {
    levels_t row4;
    levels_t row3;
    levels_t row2;
    levels_t row1;
  } scan_t;

endpackage

[hw/rtl/mkd_encoder.sv]
module mkd_encoder
  import mkd_pkg::*;
(
  input  scan_t scan,
  output code_t code
);

  levels_t rows [ROWS];
  code_t   col_code [COLS];

  assign rows[0] = scan.row1;
  assign rows[1] = scan.row2;
  assign rows[2] = scan.row3;
  assign rows[3] = scan.row4;

  // Per column: the lowest-numbered row reading low wins (code 4*c+4-r).
  always_comb begin
    for (int c = 0; c < COLS; c++) begin
      col_code[c] = KEY_NONE;
      for (int r = ROWS - 1; r >= 0; r--) begin
        if (!rows[r][c]) begin
          col_code[c] = CODE_W'(4 * (c + 1) + 4 - (r + 1));
        end
      end
    end
  end

  // A later column with a pressed key overrides earlier columns.
  always_comb begin
    code = KEY_NONE;
    for (int c = 0; c < COLS; c++) begin
      if (col_code[c] != KEY_NONE) begin
        code = col_code[c];
      end
    end
  end

endmodule

[hw/rtl/mkd_debounce.sv]
module mkd_debounce
  import mkd_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   scan_vld,
  input  code_t  code,
  input  count_t thresh,
  output logic   scan_take,
  output logic   out_valid,
  input  logic   out_stall,
  output code_t  out_press_event
);

  code_t  prev_code_r, prev_code_nxt;
  count_t equal_cnt_r, equal_cnt_nxt;
  logic   given_r, given_nxt;
  logic   out_valid_r, out_valid_nxt;
  code_t  event_r, event_nxt;
  count_t cnt_inc;

  // The result register frees up when empty or when its word is taken.
  assign scan_take = scan_vld && (!out_valid_r || !out_stall);

  assign cnt_inc = (equal_cnt_r < thresh) ? equal_cnt_r + 1'b1 : equal_cnt_r;

  // Debounce state update for one scan.
  always_comb begin
    prev_code_nxt = prev_code_r;
    equal_cnt_nxt = equal_cnt_r;
    given_nxt     = given_r;
    event_nxt     = event_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (scan_take) begin
      out_valid_nxt = 1'b1;
      event_nxt     = KEY_NONE;
      if (code != prev_code_r) begin
        prev_code_nxt = code;
        equal_cnt_nxt = '0;
      end else begin
        equal_cnt_nxt = cnt_inc;
        if (cnt_inc >= thresh) begin
          if (prev_code_r != KEY_NONE && !given_r) begin
            given_nxt = 1'b1;
            event_nxt = prev_code_r;
          end else if (prev_code_r == KEY_NONE) begin
            given_nxt = 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_code_r <= KEY_NONE;
      equal_cnt_r <= '0;
      given_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      prev_code_r <= prev_code_nxt;
      equal_cnt_r <= equal_cnt_nxt;
      given_r     <= given_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload needs no reset.
  always_ff @(posedge clk) begin
    event_r <= event_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_press_event = event_r;

endmodule

[hw/rtl/matrix_keypad_debounce_unit.sv]
// A scan word accepted into the input register is encoded, and its press event is
// registered in the result register, from which it is offered as a result word.
// Throughput: one scan word per cycle; the input and result registers form a two-stage
// pipeline, so the input stalls only when both are full and out_stall is high.
// Reset (rst_n low, synchronous): pipeline empty, last code no key, count zero,
// press not reported, stable_scans threshold 3.
module matrix_keypad_debounce_unit
  import mkd_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  input  levels_t in_row1_levels,
  input  levels_t in_row2_levels,
  input  levels_t in_row3_levels,
  input  levels_t in_row4_levels,
  output logic    out_valid,
  input  logic    out_stall,
  output code_t   out_press_event,
  input  logic    cfg_wr_en,
  input  count_t  cfg_wr_data
);

  scan_t  scan_r, scan_nxt;
  logic   scan_vld_r, scan_vld_nxt;
  count_t thresh_r, thresh_nxt;
  logic   scan_take;
  logic   in_acc;
  code_t  code;

  // Input register accepts when empty or when its word moves on.
  assign in_stall = scan_vld_r && !scan_take;
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    scan_nxt     = scan_r;
    scan_vld_nxt = scan_vld_r && !scan_take;
    thresh_nxt   = thresh_r;
    if (in_acc) begin
      scan_nxt.row1 = in_row1_levels;
      scan_nxt.row2 = in_row2_levels;
      scan_nxt.row3 = in_row3_levels;
      scan_nxt.row4 = in_row4_levels;
      scan_vld_nxt  = 1'b1;
    end
    if (cfg_wr_en) begin
      thresh_nxt = cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_vld_r <= 1'b0;
      thresh_r   <= STABLE_SCANS_RST;
    end else begin
      scan_vld_r <= scan_vld_nxt;
      thresh_r   <= thresh_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_r <= scan_nxt;
  end

  // Scan encoding.
  mkd_encoder u_encoder (
    .scan (scan_r),
    .code (code)
  );

  // Debounce state and result register.
  mkd_debounce u_debounce (
    .clk             (clk),
    .rst_n           (rst_n),
    .scan_vld        (scan_vld_r),
    .code            (code),
    .thresh          (thresh_r),
    .scan_take       (scan_take),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_press_event (out_press_event)
  );

endmodule

[bench/testbench.sv]
module testbench;
  import mkd_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_OFF_CYCLES = 60;

  logic    clk = 1'b0;
  logic    rst_n = 1'b0;
  logic    in_valid = 1'b0;
  logic    in_stall;
  levels_t in_row1_levels = '1;
  levels_t in_row2_levels = '1;
  levels_t in_row3_levels = '1;
  levels_t in_row4_levels = '1;
  logic    out_valid;
  logic    out_stall = 1'b0;
  code_t   out_press_event;
  logic    cfg_wr_en = 1'b0;
  count_t  cfg_wr_data = '0;

  // Debounce state as the block should hold it.
  code_t  last_code = KEY_NONE;
  count_t repeat_count = '0;
  logic   press_reported = 1'b0;
  count_t stable_scans_cfg = STABLE_SCANS_RST;

  code_t press_expected[$];

  int   send_gap_pct = 0;
  int   recv_gap_pct = 0;
  logic stall_hold = 1'b0;
  int   scans_sent = 0;
  int   results_checked = 0;
  int   presses_seen = 0;
  int   input_stall_cycles = 0;
  int   fail_count = 0;
  int   cycle_count = 0;

  matrix_keypad_debounce_unit i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_row1_levels (in_row1_levels),
    .in_row2_levels (in_row2_levels),
    .in_row3_levels (in_row3_levels),
    .in_row4_levels (in_row4_levels),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_press_event(out_press_event),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data)
  );

  always #5 clk = ~clk;

  // Encode one scan: the lowest pressed row wins within a column, and a later
  // column with a pressed key overrides earlier columns.
  function automatic code_t scan_key_code(scan_t s);
    logic [15:0] b;
    code_t       code;
    code_t       col_code;
    b = s;
    code = KEY_NONE;
    for (int c = 1; c <= 4; c++) begin
      col_code = KEY_NONE;
      for (int r = 4; r >= 1; r--) begin
        if (!b[4*(r-1)+c-1]) col_code = code_t'(4*c + 4 - r);
      end
      if (col_code != KEY_NONE) code = col_code;
    end
    return code;
  endfunction

  // Advance the debounce state by one scan code and return the press event.
  function automatic code_t predict_press(code_t code);
    code_t press;
    press = KEY_NONE;
    if (code != last_code) begin
      last_code = code;
      repeat_count = '0;
    end else begin
      if (repeat_count < stable_scans_cfg) repeat_count = repeat_count + 1'b1;
      if (repeat_count >= stable_scans_cfg) begin
        if (last_code != KEY_NONE && !press_reported) begin
          press_reported = 1'b1;
          press = last_code;
        end else if (last_code == KEY_NONE) begin
          press_reported = 1'b0;
        end
      end
    end
    return press;
  endfunction

  // Build a scan that encodes to the given key, with random ghost presses in
  // earlier columns and in higher rows of the same column.
  function automatic scan_t make_scan(code_t key);
    logic [15:0] b;
    int          c;
    int          r;
    b = '1;
    if (key != KEY_NONE) begin
      c = int'(key) / 4;
      r = 4*c + 4 - int'(key);
      for (int cc = 1; cc < c; cc++) begin
        for (int rr = 1; rr <= 4; rr++) b[4*(rr-1)+cc-1] = 1'($urandom_range(1));
      end
      for (int rr = r + 1; rr <= 4; rr++) b[4*(rr-1)+c-1] = 1'($urandom_range(1));
      b[4*(r-1)+c-1] = 1'b0;
    end
    return scan_t'(b);
  endfunction

  function automatic code_t pick_key();
    if ($urandom_range(3) == 0) return KEY_NONE;
    return code_t'($urandom_range(19, 4));
  endfunction

  // Offer one scan word, wait until it is taken, then queue its prediction.
  task automatic send_scan(scan_t s);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_row1_levels <= s.row1;
    in_row2_levels <= s.row2;
    in_row3_levels <= s.row3;
    in_row4_levels <= s.row4;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    press_expected.push_back(predict_press(scan_key_code(s)));
    scans_sent++;
  endtask

  task automatic hold_key(code_t key, int scans);
    repeat (scans) send_scan(make_scan(key));
  endtask

  // Stop offering and let every expected word come out.
  task automatic wait_results_done();
    in_valid <= 1'b0;
    while (press_expected.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_stable_scans(count_t value);
    wait_results_done();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    stable_scans_cfg = value;
  endtask

  // Press, direct key change, release and bounce at the reset threshold.
  task automatic test_directed();
    send_scan(scan_t'(16'hFFFF));
    send_scan(scan_t'(16'hFFFF));
    hold_key(code_t'(4), 5);
    hold_key(code_t'(19), 5);
    send_scan(scan_t'(16'h0000));
    hold_key(KEY_NONE, 4);
    hold_key(code_t'(7), 2);
    hold_key(KEY_NONE, 1);
    hold_key(code_t'(7), 4);
  endtask

  // Zero and full thresholds, and a threshold lowered below the running count.
  task automatic test_threshold_corners();
    write_stable_scans(count_t'(0));
    hold_key(code_t'(13), 2);
    hold_key(KEY_NONE, 2);
    write_stable_scans(count_t'(15));
    hold_key(code_t'(16), 16);
    hold_key(code_t'(11), 12);
    write_stable_scans(count_t'(2));
    hold_key(code_t'(11), 2);
    write_stable_scans(count_t'(1));
    hold_key(KEY_NONE, 2);
  endtask

  // Mostly held keys with random ghost presses, then bounce and raw noise.
  task automatic test_random_scans(int count, count_t threshold, int send_pct, int recv_pct);
    int    stop_at;
    int    roll;
    write_stable_scans(threshold);
    send_gap_pct = send_pct;
    recv_gap_pct = recv_pct;
    stop_at = scans_sent + count;
    while (scans_sent < stop_at) begin
      roll = $urandom_range(99);
      if (roll < 65) begin
        hold_key(pick_key(), $urandom_range(stable_scans_cfg + 3, 1));
      end else if (roll < 85) begin
        repeat ($urandom_range(5, 2)) hold_key(pick_key(), $urandom_range(2, 1));
      end else begin
        send_scan(scan_t'($urandom_range(16'hFFFF, 0)));
      end
    end
    wait_results_done();
  endtask

  // The receiver holds off for a long stretch while scans keep coming.
  task automatic test_backpressure();
    write_stable_scans(count_t'(2));
    send_gap_pct = 0;
    recv_gap_pct = 0;
    fork
      begin
        stall_hold <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        stall_hold <= 1'b0;
      end
      begin
        hold_key(code_t'($urandom_range(19, 4)), 12);
        hold_key(KEY_NONE, 6);
        hold_key(code_t'($urandom_range(19, 4)), 6);
      end
    join
    wait_results_done();
  endtask

  // Receiver stall pattern.
  always @(posedge clk) begin
    out_stall <= stall_hold || ($urandom_range(99) < recv_gap_pct);
  end

  // Compare each accepted result word with the oldest prediction.
  always @(posedge clk) begin
    code_t want;
    if (rst_n && in_valid && in_stall) input_stall_cycles++;
    if (rst_n && out_valid && !out_stall) begin
      if (press_expected.size() == 0) begin
        $error("press_event: no word expected, actual %0d", out_press_event);
        fail_count++;
      end else begin
        want = press_expected.pop_front();
        if (out_press_event !== want) begin
          $error("press_event: expected %0d, actual %0d", want, out_press_event);
          fail_count++;
        end
        if (want != KEY_NONE) presses_seen++;
        results_checked++;
      end
    end
  end

  // Guard against a hung handshake.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("** matrix_keypad_debounce_unit: FAILED **");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_threshold_corners();
    test_random_scans(105, count_t'(1), 37, 55);
    test_random_scans(105, count_t'($urandom_range(6, 2)), 55, 37);
    test_random_scans(105, count_t'($urandom_range(15, 8)), 0, 0);
    test_backpressure();
    wait_results_done();
    $display("Sent %0d scan words; checked %0d result words, %0d of them key presses.",
             scans_sent, results_checked, presses_seen);
    $display("Thresholds of zero, full scale and a lowered one were used; %0d stall cycles.",
             input_stall_cycles);
    if (fail_count == 0 && press_expected.size() == 0) begin
      $display("** matrix_keypad_debounce_unit: PASSED **");
    end else begin
      $display("** matrix_keypad_debounce_unit: FAILED **");
    end
    $finish;
  end

endmodule

[sim.f]
hw/rtl/mkd_pkg.sv
hw/rtl/mkd_encoder.sv
hw/rtl/mkd_debounce.sv
hw/rtl/matrix_keypad_debounce_unit.sv
bench/testbench.sv
